// ===== hdl/ttcm_pkg.sv =====
// Shared constants, types and tables for the tunnel texture coordinate mapper.
package ttcm_pkg;

  localparam int FIELD_WIDTH  = 640;
  localparam int FIELD_HEIGHT = 480;

  localparam logic [11:0] HALF_W = 12'(FIELD_WIDTH / 2);
  localparam logic [11:0] HALF_H = 12'(FIELD_HEIGHT / 2);

  localparam int DIV_STEPS    = 34;
  localparam int SQRT_STEPS   = 17;
  localparam int CORDIC_STEPS = 16;
  localparam int DEPTH_LAT    = DIV_STEPS + SQRT_STEPS;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int ANGLE_FRAC   = 20;

  localparam logic [33:0] DEPTH_NUM = 34'd10000000000;
  localparam logic signed [31:0] HALF_TURN = 32'sd268435456;

  typedef logic signed [35:0] cval_t;
  typedef logic signed [31:0] zval_t;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_ADVANCE       = 3'd2,
    REG_ROTATION      = 3'd3,
    REG_TEXTURE_PITCH = 3'd4,
    REG_SCREEN_PITCH  = 3'd5
  } reg_idx_t;

  function automatic zval_t atan_entry(input logic [3:0] idx);
    zval_t val;
    case (idx)
      4'd0:    val = 32'sd67108864;
      4'd1:    val = 32'sd39616676;
      4'd2:    val = 32'sd20932363;
      4'd3:    val = 32'sd10625595;
      4'd4:    val = 32'sd5333416;
      4'd5:    val = 32'sd2669308;
      4'd6:    val = 32'sd1334980;
      4'd7:    val = 32'sd667531;
      4'd8:    val = 32'sd333770;
      4'd9:    val = 32'sd166886;
      4'd10:   val = 32'sd83443;
      4'd11:   val = 32'sd41722;
      4'd12:   val = 32'sd20861;
      4'd13:   val = 32'sd10430;
      4'd14:   val = 32'sd5215;
      default: val = 32'sd2608;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/ttcm_depth.sv =====
// Pipelined depth unit: restoring division of a constant by r2, then integer square root.
module ttcm_depth
  import ttcm_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [25:0] r2,
  output logic [16:0] depth
);

  logic [25:0] div_rem_r [0:DIV_STEPS-1];
  logic [33:0] div_q_r   [0:DIV_STEPS-1];
  logic [25:0] div_d_r   [0:DIV_STEPS-1];

  genvar gd;
  generate
    for (gd = 0; gd < DIV_STEPS; gd++) begin : g_div
      logic [25:0] rem_in;
      logic [33:0] q_in;
      logic [25:0] d_in;
      logic [26:0] sh;
      logic [26:0] diff;
      if (gd == 0) begin : g_first
        assign rem_in = '0;
        assign q_in   = '0;
        assign d_in   = r2;
      end else begin : g_next
        assign rem_in = div_rem_r[gd-1];
        assign q_in   = div_q_r[gd-1];
        assign d_in   = div_d_r[gd-1];
      end
      assign sh   = {rem_in, DEPTH_NUM[DIV_STEPS-1-gd]};
      assign diff = sh - {1'b0, d_in};
      always_ff @(posedge clk) begin
        if (en) begin
          div_d_r[gd] <= d_in;
          if (sh >= {1'b0, d_in}) begin
            div_rem_r[gd] <= diff[25:0];
            div_q_r[gd]   <= {q_in[32:0], 1'b1};
          end else begin
            div_rem_r[gd] <= sh[25:0];
            div_q_r[gd]   <= {q_in[32:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  logic [18:0] sq_rem_r  [0:SQRT_STEPS-1];
  logic [16:0] sq_root_r [0:SQRT_STEPS-1];
  logic [33:0] sq_q_r    [0:SQRT_STEPS-1];

  genvar gs;
  generate
    for (gs = 0; gs < SQRT_STEPS; gs++) begin : g_sqrt
      logic [18:0] rem_in;
      logic [16:0] root_in;
      logic [33:0] q_in;
      logic [20:0] sh;
      logic [20:0] trial;
      logic [20:0] diff;
      if (gs == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign q_in    = div_q_r[DIV_STEPS-1];
      end else begin : g_next
        assign rem_in  = sq_rem_r[gs-1];
        assign root_in = sq_root_r[gs-1];
        assign q_in    = sq_q_r[gs-1];
      end
      assign sh    = {rem_in, q_in[33:32]};
      assign trial = {2'b00, root_in, 2'b01};
      assign diff  = sh - trial;
      always_ff @(posedge clk) begin
        if (en) begin
          sq_q_r[gs] <= {q_in[31:0], 2'b00};
          if (sh >= trial) begin
            sq_rem_r[gs]  <= diff[18:0];
            sq_root_r[gs] <= {root_in[15:0], 1'b1};
          end else begin
            sq_rem_r[gs]  <= sh[18:0];
            sq_root_r[gs] <= {root_in[15:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign depth = sq_root_r[SQRT_STEPS-1];

endmodule

// ===== hdl/ttcm_cordic.sv =====
// Pipelined vectoring CORDIC giving the tunnel angle in units of pi/256.
module ttcm_cordic
  import ttcm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [13:0] xin,
  input  logic signed [13:0] yin,
  output logic [8:0]         ang
);

  cval_t c_x_r [0:CORDIC_STEPS];
  cval_t c_y_r [0:CORDIC_STEPS];
  zval_t c_z_r [0:CORDIC_STEPS];
  logic [8:0] ang_r;

  cval_t xs;
  cval_t ys;
  assign xs = {{22{xin[13]}}, xin} <<< ANGLE_FRAC;
  assign ys = {{22{yin[13]}}, yin} <<< ANGLE_FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      if (xin < 0) begin
        c_x_r[0] <= -xs;
        c_y_r[0] <= -ys;
        c_z_r[0] <= (yin < 0) ? -HALF_TURN : HALF_TURN;
      end else begin
        c_x_r[0] <= xs;
        c_y_r[0] <= ys;
        c_z_r[0] <= '0;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_iter
      always_ff @(posedge clk) begin
        if (en) begin
          if (c_y_r[gi] > 0) begin
            c_x_r[gi+1] <= c_x_r[gi] + (c_y_r[gi] >>> gi);
            c_y_r[gi+1] <= c_y_r[gi] - (c_x_r[gi] >>> gi);
            c_z_r[gi+1] <= c_z_r[gi] + atan_entry(4'(gi));
          end else if (c_y_r[gi] < 0) begin
            c_x_r[gi+1] <= c_x_r[gi] - (c_y_r[gi] >>> gi);
            c_y_r[gi+1] <= c_y_r[gi] + (c_x_r[gi] >>> gi);
            c_z_r[gi+1] <= c_z_r[gi] - atan_entry(4'(gi));
          end else begin
            c_x_r[gi+1] <= c_x_r[gi];
            c_y_r[gi+1] <= c_y_r[gi];
            c_z_r[gi+1] <= c_z_r[gi];
          end
        end
      end
    end
  endgenerate

  zval_t z_fin;
  logic [31:0] z_neg;
  logic [31:0] z_mag_q;
  logic [31:0] z_pos_q;
  logic [8:0]  ang_nxt;
  assign z_fin   = c_z_r[CORDIC_STEPS];
  assign z_neg   = -z_fin;
  assign z_mag_q = z_neg >> ANGLE_FRAC;
  assign z_pos_q = z_fin >> ANGLE_FRAC;
  always_comb begin
    if (z_fin < 0) begin
      ang_nxt = 9'(-z_mag_q);
    end else begin
      ang_nxt = z_pos_q[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign ang = ang_r;

endmodule

// ===== hdl/tunnel_texture_coordinate_mapper_unit.sv =====
// Top level of the tunnel texture coordinate mapper: pipeline, stall control and registers.
//
//  channel | direction | handshake              | payload
//  in_     | request in| in_tvalid / in_tready   | in_tdata: pixel_x, pixel_y
//  out_    | result out| out_tvalid / out_tready | out_tdata: tex_u, tex_v, texel, screen
//  cfg_    | APB slave | psel, penable, pready   | six registers at 4*i
//
// One request per cycle while the output is not stalled; the depth path is a 34-step divider and a
// 17-step square root.
// Reset clears the valid bits and the registers to their defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module tunnel_texture_coordinate_mapper_unit
  import ttcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [8:0] pixel_x, [16:9] pixel_y, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [8:0] tex_u, [17:9] tex_v, [38:18] texel_address,
                                   // [58:39] screen_address, rest zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LAT     = DEPTH_LAT + 5;
  localparam int PIX_DLY = DEPTH_LAT + 3;
  localparam int ANG_DLY = DEPTH_LAT + 2 - CORDIC_LAT;

  logic [8:0]  center_x_r;
  logic [7:0]  center_y_r;
  logic [8:0]  advance_r;
  logic [8:0]  rotation_r;
  logic [12:0] tex_pitch_r;
  logic [12:0] scr_pitch_r;

  logic     wr_en;
  reg_idx_t wr_idx;
  assign cfg_pready = 1'b1;
  assign wr_en  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wr_idx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= 9'd160;
      center_y_r  <= 8'd120;
      advance_r   <= 9'd0;
      rotation_r  <= 9'd0;
      tex_pitch_r <= 13'd512;
      scr_pitch_r <= 13'd320;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_CENTER_X:      center_x_r  <= cfg_pwdata[8:0];
        REG_CENTER_Y:      center_y_r  <= cfg_pwdata[7:0];
        REG_ADVANCE:       advance_r   <= cfg_pwdata[8:0];
        REG_ROTATION:      rotation_r  <= cfg_pwdata[8:0];
        REG_TEXTURE_PITCH: tex_pitch_r <= cfg_pwdata[12:0];
        REG_SCREEN_PITCH:  scr_pitch_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_CENTER_X:      cfg_prdata = {23'd0, center_x_r};
      REG_CENTER_Y:      cfg_prdata = {24'd0, center_y_r};
      REG_ADVANCE:       cfg_prdata = {23'd0, advance_r};
      REG_ROTATION:      cfg_prdata = {23'd0, rotation_r};
      REG_TEXTURE_PITCH: cfg_prdata = {19'd0, tex_pitch_r};
      REG_SCREEN_PITCH:  cfg_prdata = {19'd0, scr_pitch_r};
      default:           cfg_prdata = '0;
    endcase
  end

  logic en;
  logic vld_r [1:LAT];
  assign en        = !vld_r[LAT] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int k = 2; k <= LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  logic [8:0]  px;
  logic [7:0]  py;
  logic [11:0] fx;
  logic [11:0] fy;
  logic signed [13:0] x_nxt;
  logic signed [13:0] y_nxt;
  assign px = in_tdata[8:0];
  assign py = in_tdata[16:9];
  assign fx = 12'(px) + 12'(center_x_r) - HALF_W;
  assign fy = 12'(py) + 12'(center_y_r) - HALF_H;
  assign x_nxt = (fx == '0) ? 14'sd1 : 14'($signed(fx) * 14'sd10);
  assign y_nxt = 14'($signed(fy) * 14'sd10);

  logic signed [13:0] x_r;
  logic signed [13:0] y_r;
  logic [25:0] xx_r;
  logic [25:0] yy_r;
  logic [25:0] r2_r;
  logic [16:0] pix_d_r [0:PIX_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      xx_r <= 26'(x_r * x_r);
      yy_r <= 26'(y_r * y_r);
      r2_r <= xx_r + yy_r;
      pix_d_r[0] <= {py, px};
      for (int k = 1; k < PIX_DLY; k++) begin
        pix_d_r[k] <= pix_d_r[k-1];
      end
    end
  end

  logic [16:0] depth;
  logic [8:0]  ang;

  ttcm_depth u_depth (
    .clk   (clk),
    .en    (en),
    .r2    (r2_r),
    .depth (depth)
  );

  ttcm_cordic u_cordic (
    .clk (clk),
    .en  (en),
    .xin (x_r),
    .yin (y_r),
    .ang (ang)
  );

  logic [8:0] ang_d_r [0:ANG_DLY-1];
  always_ff @(posedge clk) begin
    if (en) begin
      ang_d_r[0] <= ang;
      for (int k = 1; k < ANG_DLY; k++) begin
        ang_d_r[k] <= ang_d_r[k-1];
      end
    end
  end

  logic [8:0]  u_r;
  logic [8:0]  v_r;
  logic [19:0] scr_r;
  logic [8:0]  px_end;
  logic [7:0]  py_end;
  assign px_end = pix_d_r[PIX_DLY-1][8:0];
  assign py_end = pix_d_r[PIX_DLY-1][16:9];

  logic [8:0]  tex_u_r;
  logic [8:0]  tex_v_r;
  logic [20:0] texel_r;
  logic [19:0] screen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r      <= ang_d_r[ANG_DLY-1] + rotation_r;
      v_r      <= depth[8:0] + advance_r;
      scr_r    <= 20'(21'(px_end) + 21'(py_end) * 21'(scr_pitch_r));
      tex_u_r  <= u_r;
      tex_v_r  <= v_r;
      texel_r  <= 21'(22'(u_r) + 22'(v_r) * 22'(tex_pitch_r));
      screen_r <= scr_r;
    end
  end

  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = {5'd0, screen_r, texel_r, tex_v_r, tex_u_r};

endmodule

// ===== hdl/ttcm_checker.sv =====
// Port-level checker for the tunnel texture coordinate mapper, bound to the top level.
module ttcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        cfg_pready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off without output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready && (in_tready || out_tvalid))
    else $error("config port or pipeline blocked");

endmodule

bind tunnel_texture_coordinate_mapper_unit ttcm_checker u_ttcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

// ===== tb/sv/tunnel_texture_coordinate_mapper_unit_chk.sv =====
`timescale 1ns / 100ps
// Checker for the tunnel texture coordinate mapper: predicts texture coordinates and addresses.
module tunnel_texture_coordinate_mapper_unit_chk
  import ttcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [8:0]  tex_u;
    logic [8:0]  tex_v;
    logic [20:0] texel_address;
    logic [19:0] screen_address;
  } texcoord_t;

  texcoord_t coord_q[$];

  logic [8:0]  cx, adv, rot;
  logic [7:0]  cy;
  logic [12:0] tpitch, spitch;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int unsigned tunnel_depth(longint unsigned r2);
    int unsigned d;
    longint unsigned c;
    d = 0;
    for (int b = 16; b >= 0; b--) begin
      c = d | (1 << b);
      if (c * c * r2 <= 64'd10000000000) d = d | (1 << b);
    end
    return d;
  endfunction

  function automatic int tunnel_angle(longint xi, longint yi);
    longint x, y, z, nx;
    longint tab[16] = '{67108864, 39616676, 20932363, 10625595, 5333416, 2669308,
                        1334980, 667531, 333770, 166886, 83443, 41722, 20861,
                        10430, 5215, 2608};
    z = 0;
    if (xi < 0) begin
      z = (yi < 0) ? -longint'(HALF_TURN) : longint'(HALF_TURN);
      x = -xi;
      y = -yi;
    end else begin
      x = xi;
      y = yi;
    end
    x = x * (1 << ANGLE_FRAC);
    y = y * (1 << ANGLE_FRAC);
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        x = nx;
        z = z + tab[i];
      end else if (y < 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        x = nx;
        z = z - tab[i];
      end
    end
    if (z >= 0) return int'(z / (1 << ANGLE_FRAC));
    return -int'((-z) / (1 << ANGLE_FRAC));
  endfunction

  function automatic texcoord_t map_pixel(logic [8:0] px, logic [7:0] py);
    texcoord_t r;
    longint fx, fy, xs, ys;
    int ang;
    int unsigned dep, u32;
    fx = longint'(px) + longint'(cx) - FIELD_WIDTH / 2;
    fy = longint'(py) + longint'(cy) - FIELD_HEIGHT / 2;
    xs = (fx == 0) ? 1 : fx * 10;
    ys = fy * 10;
    dep = tunnel_depth(xs * xs + ys * ys);
    ang = tunnel_angle(xs, ys);
    u32 = int'(ang) + rot;
    r.tex_u = u32[8:0];
    r.tex_v = 9'(dep + adv);
    r.texel_address = 21'(longint'(r.tex_u) + longint'(r.tex_v) * tpitch);
    r.screen_address = 20'(longint'(px) + longint'(py) * spitch);
    return r;
  endfunction

  always @(posedge clk) begin
    texcoord_t want, got;
    if (!rst_n) begin
      cx <= 9'd160;
      cy <= 8'd120;
      adv <= '0;
      rot <= '0;
      tpitch <= 13'd512;
      spitch <= 13'd320;
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_CENTER_X:      cx <= cfg_pwdata[8:0];
          REG_CENTER_Y:      cy <= cfg_pwdata[7:0];
          REG_ADVANCE:       adv <= cfg_pwdata[8:0];
          REG_ROTATION:      rot <= cfg_pwdata[8:0];
          REG_TEXTURE_PITCH: tpitch <= cfg_pwdata[12:0];
          REG_SCREEN_PITCH:  spitch <= cfg_pwdata[12:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) coord_q.push_back(map_pixel(in_tdata[8:0], in_tdata[16:9]));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[8:0], out_tdata[17:9], out_tdata[38:18], out_tdata[58:39]};
        if (coord_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = coord_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("u %0d/%0d v %0d/%0d texel %0d/%0d screen %0d/%0d (exp/act)",
                       want.tex_u, got.tex_u, want.tex_v, got.tex_v,
                       want.texel_address, got.texel_address,
                       want.screen_address, got.screen_address);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= coord_q.size();
    end
  end

endmodule

// ===== tb/sv/tunnel_texture_coordinate_mapper_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the tunnel texture coordinate mapper: stimulus, registers and verdict.
module tunnel_texture_coordinate_mapper_unit_tb;
  import ttcm_pkg::*;

  localparam int DRAIN = 80;
  localparam int LIMIT = 20000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready;
  logic [23:0] in_tdata;
  logic [63:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending_count;
  int          send_idle, recv_stall, hold_off, idle_cycles;

  tunnel_texture_coordinate_mapper_unit dut (.*);
  tunnel_texture_coordinate_mapper_unit_chk chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [8:0] px, logic [7:0] py);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'd0, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_pixel(9'($urandom), 8'($urandom));
      else
        send_pixel(9'($urandom_range(319)), 8'($urandom_range(239)));
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // field centre, axes, diagonals, corners and extremes
    send_pixel(9'd160, 8'd120);
    send_pixel(9'd160, 8'd0);
    send_pixel(9'd160, 8'd239);
    send_pixel(9'd0, 8'd120);
    send_pixel(9'd319, 8'd120);
    send_pixel(9'd170, 8'd130);
    send_pixel(9'd150, 8'd110);
    send_pixel(9'd170, 8'd110);
    send_pixel(9'd150, 8'd130);
    send_pixel(9'd0, 8'd0);
    send_pixel(9'd319, 8'd239);
    send_pixel(9'd511, 8'd255);
    send_pixel(9'd0, 8'd255);
    send_pixel(9'd511, 8'd0);
    send_pixel(9'd161, 8'd120);
    send_pixel(9'd159, 8'd120);
    drain();

    write_reg(REG_CENTER_X, 32'd320);
    write_reg(REG_CENTER_Y, 32'd240);
    write_reg(REG_ADVANCE, 32'd511);
    write_reg(REG_ROTATION, 32'd511);
    write_reg(REG_TEXTURE_PITCH, 32'd4096);
    write_reg(REG_SCREEN_PITCH, 32'd4096);
    send_pixel(9'd0, 8'd0);
    send_pixel(9'd511, 8'd255);
    send_pixel(9'd319, 8'd239);
    random_pixels(150);
    drain();

    send_idle = 60;
    write_reg(REG_CENTER_X, 32'd0);
    write_reg(REG_CENTER_Y, 32'd0);
    write_reg(REG_ADVANCE, 32'd0);
    write_reg(REG_ROTATION, 32'd0);
    write_reg(REG_TEXTURE_PITCH, 32'd0);
    write_reg(REG_SCREEN_PITCH, 32'd0);
    random_pixels(250);
    drain();

    send_idle = 0;
    recv_stall = 60;
    write_reg(REG_CENTER_X, 32'hFFFF_FFFF);
    write_reg(REG_CENTER_Y, 32'hFFFF_FFFF);
    write_reg(REG_TEXTURE_PITCH, 32'd1);
    write_reg(REG_SCREEN_PITCH, 32'd8191);
    random_pixels(250);
    drain();

    send_idle = 26;
    recv_stall = 26;
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_CENTER_X, $urandom_range(320));
      write_reg(REG_CENTER_Y, $urandom_range(240));
      write_reg(REG_ADVANCE, $urandom);
      write_reg(REG_ROTATION, $urandom);
      write_reg(REG_TEXTURE_PITCH, $urandom_range(4096, 1));
      write_reg(REG_SCREEN_PITCH, $urandom_range(4096, 1));
      random_pixels(100);
      drain();
    end

    send_idle = 0;
    recv_stall = 0;
    hold_off <= 300;
    random_pixels(200);
    recv_stall = 10;
    random_pixels(100);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ttcm_pkg.sv
hdl/ttcm_depth.sv
hdl/ttcm_cordic.sv
hdl/tunnel_texture_coordinate_mapper_unit.sv
hdl/ttcm_checker.sv
tb/sv/tunnel_texture_coordinate_mapper_unit_chk.sv
tb/sv/tunnel_texture_coordinate_mapper_unit_tb.sv
